// File: design/gsss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Group strings by symbol set: shared definitions
// Sizes of the symbol alphabet and the group table, the search sequencer
// states and the control bundles between the top level and the search unit.
// ----------------------------------------------------------------------------
package gsss_pkg;

   localparam int MAX_GROUPS    = 64;
   localparam int ALPHABET_BITS = 256;

   localparam int SYM_W      = 8;
   localparam int SYM_CMP_W  = SYM_W + 1;
   localparam int SYM_IDX_W  = $clog2(ALPHABET_BITS);
   localparam int MASK_W     = ALPHABET_BITS;
   localparam int ADDR_W     = $clog2(MAX_GROUPS);
   localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
   localparam int GROUP_ID_W = 6;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DONE
   } search_state_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic ack;
   } search_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [GROUP_ID_W-1:0] group_id;
      logic                  new_group;
      logic                  table_full;
   } search_rsp_type;

endpackage
`default_nettype wire

// File: design/gsss_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Group table search
// Holds the stored symbol sets in a synchronous memory and walks the used
// entries one read per cycle, comparing each against the finished mask.
// A miss with room left writes the mask as a new group.
// ----------------------------------------------------------------------------
module gsss_search (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gsss_pkg::search_cmd_type        cmd,
   input  wire logic [gsss_pkg::MASK_W-1:0]     key,
   output gsss_pkg::search_rsp_type             rsp
);

   logic [gsss_pkg::MASK_W-1:0] key_mem [gsss_pkg::MAX_GROUPS];
   logic [gsss_pkg::MASK_W-1:0] rd_data_ff;

   gsss_pkg::search_state_type   state_ff, state_in;
   logic [gsss_pkg::CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic [gsss_pkg::ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [gsss_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [gsss_pkg::GROUP_ID_W-1:0] res_group_id_ff, res_group_id_in;
   logic                         res_new_ff, res_new_in;
   logic                         res_full_ff, res_full_in;

   logic hit;
   logic issue;
   logic finish;
   logic has_room;
   logic store;

   // The compare stage sees the entry read in the previous cycle.
   assign hit      = cmp_valid_ff && (rd_data_ff == key);
   assign issue    = (state_ff == gsss_pkg::S_SEARCH) && !hit && (rd_idx_ff < count_ff);
   assign finish   = (state_ff == gsss_pkg::S_SEARCH) && !issue && (hit || !cmp_valid_ff);
   assign has_room = count_ff < gsss_pkg::CNT_W'(gsss_pkg::MAX_GROUPS);
   assign store    = finish && !hit && has_room;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsss_pkg::S_IDLE: begin
            if (cmd.start) state_in = gsss_pkg::S_SEARCH;
         end
         gsss_pkg::S_SEARCH: begin
            if (finish) state_in = gsss_pkg::S_DONE;
         end
         gsss_pkg::S_DONE: begin
            if (cmd.ack) state_in = gsss_pkg::S_IDLE;
         end
         default: begin
            state_in = gsss_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.done       = (state_ff == gsss_pkg::S_DONE);
      rsp.group_id   = res_group_id_ff;
      rsp.new_group  = res_new_ff;
      rsp.table_full = res_full_ff;
   end

   always_comb begin
      rd_idx_in       = rd_idx_ff;
      cmp_valid_in    = issue;
      cmp_idx_in      = cmp_idx_ff;
      count_in        = count_ff;
      res_group_id_in = res_group_id_ff;
      res_new_in      = res_new_ff;
      res_full_in     = res_full_ff;

      if (cmd.start) begin
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + gsss_pkg::CNT_W'(1);
      end
      if (issue) begin
         cmp_idx_in = rd_idx_ff[gsss_pkg::ADDR_W-1:0];
      end

      if (cmd.clear) begin
         count_in = '0;
      end else if (store) begin
         count_in = count_ff + gsss_pkg::CNT_W'(1);
      end

      if (finish) begin
         res_new_in  = store;
         res_full_in = !hit && !has_room;
         if (hit) begin
            res_group_id_in = gsss_pkg::GROUP_ID_W'(cmp_idx_ff);
         end else if (has_room) begin
            res_group_id_in = gsss_pkg::GROUP_ID_W'(count_ff);
         end else begin
            res_group_id_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsss_pkg::S_IDLE;
         cmp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      res_group_id_ff <= res_group_id_in;
      res_new_ff      <= res_new_in;
      res_full_ff     <= res_full_in;
   end

   // Writes happen only when a search ends, never in a cycle that issues a read.
   always_ff @(posedge clock) begin
      if (store) begin
         key_mem[count_ff[gsss_pkg::ADDR_W-1:0]] <= key;
      end
      if (issue) begin
         rd_data_ff <= key_mem[rd_idx_ff[gsss_pkg::ADDR_W-1:0]];
      end
   end

endmodule
`default_nettype wire

// File: design/group_strings_by_symbol_set_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Group strings by symbol set
// Gathers each string's symbols into a presence mask and reports the group
// number of the set, opening a new group on first appearance with room left.
// ----------------------------------------------------------------------------
// An item without end_of_string is taken with no search. An item that ends
// a string starts a search of the group table memory, which reads one
// stored set per cycle, so the end-of-string cost grows with the position
// of a matching group, or with the number of groups held when the set is
// new. No new item is taken until that result has moved into the output
// register. start_of_batch empties the table at once; it needs no clearing
// pass.
module group_strings_by_symbol_set_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gsss_pkg::SYM_W-1:0]        req_symbol,
   input  wire logic                              req_symbol_valid,
   input  wire logic                              req_end_of_string,
   input  wire logic                              req_start_of_batch,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gsss_pkg::GROUP_ID_W-1:0]        rsp_group_id,
   output logic                                   rsp_new_group,
   output logic                                   rsp_table_full
);

   logic [gsss_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [gsss_pkg::MASK_W-1:0] mask_set;
   logic                        busy_ff, busy_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gsss_pkg::GROUP_ID_W-1:0] rsp_group_id_ff, rsp_group_id_in;
   logic                        rsp_new_group_ff, rsp_new_group_in;
   logic                        rsp_table_full_ff, rsp_table_full_in;

   logic req_xfer;
   logic sym_hit;
   logic load_rsp;

   gsss_pkg::search_cmd_type srch_cmd;
   gsss_pkg::search_rsp_type srch_rsp;

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign sym_hit   = req_symbol_valid &&
                      (gsss_pkg::SYM_CMP_W'(req_symbol) <
                       gsss_pkg::SYM_CMP_W'(gsss_pkg::ALPHABET_BITS));
   assign load_rsp  = srch_rsp.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mask_set = '0;
      if (sym_hit) begin
         mask_set[req_symbol[gsss_pkg::SYM_IDX_W-1:0]] = 1'b1;
      end
   end

   always_comb begin
      srch_cmd.start = req_xfer && req_end_of_string;
      srch_cmd.clear = req_xfer && req_start_of_batch;
      srch_cmd.ack   = load_rsp;
   end

   gsss_search u_search (
      .clock (clock),
      .reset (reset),
      .cmd   (srch_cmd),
      .key   (mask_ff),
      .rsp   (srch_rsp)
   );

   always_comb begin
      mask_in           = mask_ff;
      busy_in           = busy_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_group_id_in   = rsp_group_id_ff;
      rsp_new_group_in  = rsp_new_group_ff;
      rsp_table_full_in = rsp_table_full_ff;

      if (req_xfer) begin
         mask_in = mask_ff | mask_set;
         if (req_end_of_string) busy_in = 1'b1;
      end

      // The mask is released for the next string once its result is registered.
      if (load_rsp) begin
         mask_in           = '0;
         busy_in           = 1'b0;
         rsp_valid_in      = 1'b1;
         rsp_group_id_in   = srch_rsp.group_id;
         rsp_new_group_in  = srch_rsp.new_group;
         rsp_table_full_in = srch_rsp.table_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_group_id_ff   <= rsp_group_id_in;
      rsp_new_group_ff  <= rsp_new_group_in;
      rsp_table_full_ff <= rsp_table_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_group_id   = rsp_group_id_ff;
   assign rsp_new_group  = rsp_new_group_ff;
   assign rsp_table_full = rsp_table_full_ff;

   // A search result may only stand while a string end is outstanding.
   assert property (@(posedge clock) disable iff (reset)
      srch_rsp.done |-> busy_ff)
      else $error("search result without an outstanding string end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_group_ff && rsp_table_full_ff))
      else $error("result flags both a new group and a full table");

   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(load_rsp)) |-> (mask_ff == '0 && !busy_ff))
      else $error("mask or busy flag not cleared after a result transfer");

endmodule
`default_nettype wire
